[hw/rtl/swd_bse_pkg.sv]
package swd_bse_pkg;

   localparam int DATA_BITS  = 32;
   localparam int LEVEL_BITS = 33;
   localparam int COUNT_BITS = 6;
   localparam logic [COUNT_BITS-1:0] MAX_COUNT = 6'd32;

   typedef enum logic [1:0] {
      KIND_READ      = 2'd0,
      KIND_READ_PAR  = 2'd1,
      KIND_WRITE     = 2'd2,
      KIND_WRITE_PAR = 2'd3
   } kind_type;

   typedef struct packed {
      logic                 clock_pulse;
      logic                 dio_drive;
      logic                 dio_level;
      logic [DATA_BITS-1:0] read_data;
      logic                 parity_error;
      logic                 last;
   } rsp_item_type;

   typedef struct packed {
      logic                 start;
      logic [DATA_BITS-1:0] word;
   } par_req_type;

   typedef struct packed {
      logic busy;
      logic parity;
   } par_status_type;

endpackage

[hw/rtl/swd_bit_sequence_engine.sv]
// channel  | dir | handshake             | beat
// req_     | in  | req_valid/req_ready   | kind, bit_count, write_data, line_levels
// rsp_     | out | rsp_valid/rsp_ready   | clock_pulse, dio_drive, dio_level,
//          |     |                       | read_data, parity_error, last
//
// a command of n data bits gives up to n+4 beats; rsp_ready low or a wait for write parity holds them
// a command steps through accept, turnaround, data, end of data, parity, turn back and settle, as needed
// write parity waits for the serial parity unit, started at accept over min(WORD_BITS,32) bits of the word
// reset leaves the line driven and high, the sequencer idle and the output register empty
// req_ready rises again as soon as the settle beat sits in the output register
module swd_bit_sequence_engine #(
   parameter int WORD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic [swd_bse_pkg::COUNT_BITS-1:0]  req_bit_count,
   input  logic [swd_bse_pkg::DATA_BITS-1:0]   req_write_data,
   input  logic [swd_bse_pkg::LEVEL_BITS-1:0]  req_line_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_clock_pulse,
   output logic                                rsp_dio_drive,
   output logic                                rsp_dio_level,
   output logic [swd_bse_pkg::DATA_BITS-1:0]   rsp_read_data,
   output logic                                rsp_parity_error,
   output logic                                rsp_last
);
   import swd_bse_pkg::*;

   logic           emit_valid;
   logic           emit_ready;
   rsp_item_type   emit_item;
   par_req_type    par_req;
   par_status_type par_status;

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   item_ff, item_in;

   swd_bse_seq #(
      .WORD_BITS (WORD_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_bit_count   (req_bit_count),
      .req_write_data  (req_write_data),
      .req_line_levels (req_line_levels),
      .emit_valid      (emit_valid),
      .emit_ready      (emit_ready),
      .emit_item       (emit_item),
      .par_req         (par_req),
      .par_status      (par_status)
   );

   swd_bse_par #(
      .WORD_BITS (WORD_BITS)
   ) u_par (
      .clock      (clock),
      .reset      (reset),
      .par_req    (par_req),
      .par_status (par_status)
   );

   // output register
   assign emit_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      item_in      = item_ff;
      if (emit_valid && emit_ready) begin
         rsp_valid_in = 1'b1;
         item_in      = emit_item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clock_pulse  = item_ff.clock_pulse;
   assign rsp_dio_drive    = item_ff.dio_drive;
   assign rsp_dio_level    = item_ff.dio_level;
   assign rsp_read_data    = item_ff.read_data;
   assign rsp_parity_error = item_ff.parity_error;
   assign rsp_last         = item_ff.last;

   a_settle_no_pulse : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !rsp_clock_pulse)
      else $error("settle beat carries a clock pulse");

   a_results_only_on_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_read_data == '0 && !rsp_parity_error))
      else $error("read results on a non-final beat");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new command taken while one is in progress");

   a_pulse_only_while_busy : assert property (@(posedge clock) disable iff (reset)
      (emit_valid && emit_item.clock_pulse) |-> !req_ready)
      else $error("clock pulse beat produced while idle");

endmodule

[hw/rtl/swd_bse_par.sv]
module swd_bse_par #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  swd_bse_pkg::par_req_type    par_req,
   output swd_bse_pkg::par_status_type par_status
);
   import swd_bse_pkg::*;

   localparam int PAR_BITS = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
   localparam logic [COUNT_BITS-1:0] PAR_COUNT = COUNT_BITS'(PAR_BITS);

   logic [DATA_BITS-1:0]  shift_ff, shift_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  acc_ff, acc_in;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      if (par_req.start) begin
         shift_in = par_req.word;
         count_in = PAR_COUNT;
         acc_in   = 1'b0;
      end else if (count_ff != '0) begin
         acc_in   = acc_ff ^ shift_ff[0];
         shift_in = {1'b0, shift_ff[DATA_BITS-1:1]};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign par_status.busy   = (count_ff != '0);
   assign par_status.parity = acc_ff;

endmodule

[hw/rtl/swd_bse_seq.sv]
module swd_bse_seq #(
   parameter int WORD_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_kind,
   input  logic [swd_bse_pkg::COUNT_BITS-1:0]      req_bit_count,
   input  logic [swd_bse_pkg::DATA_BITS-1:0]       req_write_data,
   input  logic [swd_bse_pkg::LEVEL_BITS-1:0]      req_line_levels,
   output logic                                    emit_valid,
   input  logic                                    emit_ready,
   output swd_bse_pkg::rsp_item_type               emit_item,
   output swd_bse_pkg::par_req_type                par_req,
   input  swd_bse_pkg::par_status_type             par_status
);
   import swd_bse_pkg::*;

   localparam logic [COUNT_BITS-1:0] WORD_N = COUNT_BITS'(WORD_BITS);
   localparam logic [COUNT_BITS-1:0] TWO_BITS = COUNT_BITS'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TURN,
      ST_DATA,
      ST_PARITY,
      ST_BACK,
      ST_SETTLE
   } state_type;

   state_type             state_ff, state_in;
   kind_type              kind_ff, kind_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [DATA_BITS-1:0]  word_ff, word_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [DATA_BITS-1:0]  pos_ff, pos_in;
   logic [DATA_BITS-1:0]  rd_ff, rd_in;
   logic                  rpar_ff, rpar_in;
   logic                  perr_ff, perr_in;
   logic                  driven_ff, driven_in;
   logic                  lvl_ff, lvl_in;
   logic                  is_read;
   logic                  has_par;
   logic [COUNT_BITS-1:0] n_sat;

   assign is_read = (kind_ff == KIND_READ) || (kind_ff == KIND_READ_PAR);
   assign has_par = (kind_ff == KIND_READ_PAR) || (kind_ff == KIND_WRITE_PAR);
   assign n_sat   = (req_bit_count > MAX_COUNT) ? MAX_COUNT : req_bit_count;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      word_in   = word_ff;
      level_in  = level_ff;
      pos_in    = pos_ff;
      rd_in     = rd_ff;
      rpar_in   = rpar_ff;
      perr_in   = perr_ff;
      driven_in = driven_ff;
      lvl_in    = lvl_ff;

      par_req.start = 1'b0;
      par_req.word  = req_write_data;

      emit_valid             = 1'b0;
      emit_item.clock_pulse  = 1'b1;
      emit_item.dio_drive    = driven_ff;
      emit_item.dio_level    = lvl_ff;
      emit_item.read_data    = '0;
      emit_item.parity_error = 1'b0;
      emit_item.last         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in       = kind_type'(req_kind);
               count_in      = n_sat;
               n_in          = n_sat;
               word_in       = req_write_data;
               level_in      = req_line_levels;
               pos_in        = DATA_BITS'(1);
               rd_in         = '0;
               rpar_in       = 1'b0;
               perr_in       = 1'b0;
               par_req.start = 1'b1;
               // direction change needed: read while driving, write while released
               if (!req_kind[1] == driven_ff) begin
                  state_in = ST_TURN;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_TURN: begin
            emit_valid          = 1'b1;
            emit_item.dio_drive = 1'b0;
            if (emit_ready) begin
               if (is_read) begin
                  driven_in = 1'b0;
               end else begin
                  driven_in = 1'b1;
                  lvl_in    = 1'b1;
               end
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (count_ff == '0) begin
               if (!is_read && (n_ff == TWO_BITS)) begin
                  lvl_in = 1'b1;
               end
               state_in = has_par ? ST_PARITY : ST_SETTLE;
            end else begin
               emit_valid = 1'b1;
               if (!is_read) begin
                  emit_item.dio_level = word_ff[0];
               end
               if (emit_ready) begin
                  count_in = count_ff - 1'b1;
                  if (is_read) begin
                     rd_in    = rd_ff | (pos_ff & {DATA_BITS{level_ff[0]}});
                     rpar_in  = rpar_ff ^ level_ff[0];
                     level_in = {1'b0, level_ff[LEVEL_BITS-1:1]};
                     pos_in   = {pos_ff[DATA_BITS-2:0], 1'b0};
                  end else begin
                     lvl_in  = word_ff[0];
                     word_in = {1'b0, word_ff[DATA_BITS-1:1]};
                  end
               end
            end
         end
         ST_PARITY: begin
            if (is_read) begin
               emit_valid = 1'b1;
               if (emit_ready) begin
                  perr_in  = rpar_ff ^ level_ff[0];
                  state_in = (n_ff == WORD_N) ? ST_BACK : ST_SETTLE;
               end
            end else if (!par_status.busy) begin
               emit_valid          = 1'b1;
               emit_item.dio_level = par_status.parity;
               if (emit_ready) begin
                  lvl_in   = par_status.parity;
                  state_in = ST_SETTLE;
               end
            end
         end
         ST_BACK: begin
            emit_valid = 1'b1;
            if (emit_ready) begin
               driven_in = 1'b1;
               lvl_in    = 1'b1;
               state_in  = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            emit_valid             = 1'b1;
            emit_item.clock_pulse  = 1'b0;
            emit_item.read_data    = rd_ff;
            emit_item.parity_error = perr_ff;
            emit_item.last         = 1'b1;
            if (emit_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         driven_ff <= 1'b1;
         lvl_ff    <= 1'b1;
      end else begin
         state_ff  <= state_in;
         driven_ff <= driven_in;
         lvl_ff    <= lvl_in;
      end
      kind_ff  <= kind_in;
      count_ff <= count_in;
      n_ff     <= n_in;
      word_ff  <= word_in;
      level_ff <= level_in;
      pos_ff   <= pos_in;
      rd_ff    <= rd_in;
      rpar_ff  <= rpar_in;
      perr_ff  <= perr_in;
   end

endmodule
